>>> design/nfw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfw_pkg
// Shared types and constants of the NOR flash model with wear counters.
// ----------------------------------------------------------------------------
package nfw_pkg;

  localparam int MEM_BYTES   = 65536;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int NUM_SECTORS = 256;
  localparam int SEC_W       = $clog2(NUM_SECTORS);
  localparam int LEN_W       = 17;
  localparam int WEAR_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [7:0] ERASED_BYTE  = 8'hff;
  localparam logic [7:0] BAD_READ     = 8'h55;
  localparam logic signed [WEAR_W-1:0] WEAR_MAX = 16'sh7fff;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ERASE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISALIGN = 2'd1,
    STAT_BOUNDS   = 2'd2,
    STAT_CLOSED   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_OPEN   = 3'd0,
    CFG_GRAN_LOG2   = 3'd1,
    CFG_SECTOR_LOG2 = 3'd2,
    CFG_AREA_BYTES  = 3'd3,
    CFG_BAD_ENABLE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic              wen;
    logic              ren;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } byte_req_t;

  typedef struct packed {
    logic                     wen;
    logic                     ren;
    logic [SEC_W-1:0]         addr;
    logic signed [WEAR_W-1:0] wdata;
  } wear_req_t;

endpackage
`default_nettype wire

>>> design/nfw_byte_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfw_byte_ram
// Single-port byte store, registered read data held until the next read.
// ----------------------------------------------------------------------------
module nfw_byte_ram (
  input  wire logic               clk,
  input  wire nfw_pkg::byte_req_t req,
  output logic [7:0]              rdata
);

  logic [7:0] mem [nfw_pkg::MEM_BYTES];

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.ren) begin
      rdata <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

>>> design/nfw_wear_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfw_wear_ram
// Wear counter table; per-entry valid bits make unwritten entries read zero.
// ----------------------------------------------------------------------------
module nfw_wear_ram (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire nfw_pkg::wear_req_t                req,
  output logic signed [nfw_pkg::WEAR_W-1:0]      rdata
);

  logic signed [nfw_pkg::WEAR_W-1:0] mem [nfw_pkg::NUM_SECTORS];
  logic [nfw_pkg::NUM_SECTORS-1:0]   valid;
  logic signed [nfw_pkg::WEAR_W-1:0] mem_q;
  logic                              valid_q;

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.ren) begin
      mem_q <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (req.wen) begin
        valid[req.addr] <= 1'b1;
      end
      if (req.ren) begin
        valid_q <= valid[req.addr];
      end
    end
  end

  assign rdata = valid_q ? mem_q : '0;

endmodule
`default_nettype wire

>>> design/nor_flash_model_with_wear_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nor_flash_model_with_wear_top
// NOR flash area model: byte store, per-sector wear table, one result per item.
// ----------------------------------------------------------------------------
// One item at a time. The byte store and the wear table are read, and the item
// is checked, at the accepting edge. In the cycle after, once the output
// register is free, a write programs its byte and the result of a read, write,
// no-op or rejected item is loaded. An erase that passes its checks updates the
// wear table in the cycle after acceptance. It then fills the single-port byte
// store with 0xff one byte per cycle, and loads its result once the fill is done
// and the output register is free. A new item is accepted while the previous
// result still waits in the output register. That item then waits in its check
// cycle, or after its fill, until the output register drains. The wear table
// clears at reset through per-sector valid bits. The byte store has no reset
// and must be erased before it is used.
module nor_flash_model_with_wear_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [nfw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nfw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input items
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // start_addr[15:0], length[32:16], offset[48:33], wdata[56:49], mark_bad[57]
  input  wire logic [63:0]                      s_tdata,
  // op[1:0]
  input  wire logic [1:0]                       s_tuser,
  // results
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // status[1:0], rdata[9:2], sector_wear[25:10]
  output logic [31:0]                           m_tdata
);

  localparam int AW = nfw_pkg::ADDR_W;
  localparam int LW = nfw_pkg::LEN_W;
  localparam int SW = nfw_pkg::SEC_W;
  localparam int WW = nfw_pkg::WEAR_W;

  // configuration registers
  logic        area_open;
  logic [3:0]  granularity_log2;
  logic [4:0]  sector_log2;
  logic [16:0] area_bytes;
  logic        bad_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_open        <= 1'b0;
      granularity_log2 <= 4'd0;
      sector_log2      <= 5'd12;
      area_bytes       <= 17'd65536;
      bad_enable       <= 1'b0;
    end else if (cfg_we) begin
      unique case (nfw_pkg::cfg_idx_t'(cfg_index))
        nfw_pkg::CFG_AREA_OPEN:   area_open        <= cfg_wdata[0];
        nfw_pkg::CFG_GRAN_LOG2:   granularity_log2 <= cfg_wdata[3:0];
        nfw_pkg::CFG_SECTOR_LOG2: sector_log2      <= cfg_wdata[4:0];
        nfw_pkg::CFG_AREA_BYTES:  area_bytes       <= cfg_wdata[16:0];
        nfw_pkg::CFG_BAD_ENABLE:  bad_enable       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input fields
  nfw_pkg::op_t  in_op;
  logic [AW-1:0] in_addr;
  logic [LW-1:0] in_len;
  logic [AW-1:0] in_off;
  logic [7:0]    in_wd;
  logic          in_mb;

  assign in_op   = nfw_pkg::op_t'(s_tuser);
  assign in_addr = s_tdata[15:0];
  assign in_len  = s_tdata[32:16];
  assign in_off  = s_tdata[48:33];
  assign in_wd   = s_tdata[56:49];
  assign in_mb   = s_tdata[57];

  // checks at acceptance
  logic [4:0]       sec_shift;
  logic [3:0]       gran;
  logic [16:0]      smask;
  logic [8:0]       gmask;
  logic [16:0]      lim;
  logic             in_bounds;
  logic             off_bad;
  logic             wr_mis;
  logic             er_mis;
  logic [SW-1:0]    in_sec;
  nfw_pkg::status_t in_status;

  always_comb begin
    if (sector_log2 < 5'd8) begin
      sec_shift = 5'd8;
    end else if (sector_log2 > 5'd16) begin
      sec_shift = 5'd16;
    end else begin
      sec_shift = sector_log2;
    end
    gran      = (granularity_log2 > 4'd8) ? 4'd8 : granularity_log2;
    smask     = (17'd1 << sec_shift) - 17'd1;
    gmask     = (9'd1 << gran) - 9'd1;
    lim       = (area_bytes > 17'(nfw_pkg::MEM_BYTES)) ? 17'(nfw_pkg::MEM_BYTES) : area_bytes;
    in_bounds = ({2'b00, in_addr} + {1'b0, in_len}) <= {1'b0, lim};
    off_bad   = {1'b0, in_off} >= in_len;
    wr_mis    = ((in_addr[8:0] & gmask) != 9'd0) || ((in_len[8:0] & gmask) != 9'd0);
    er_mis    = (in_addr & smask[AW-1:0]) != '0;
    in_sec    = SW'(in_addr >> sec_shift);
    if (!area_open) begin
      in_status = nfw_pkg::STAT_CLOSED;
    end else begin
      unique case (in_op)
        nfw_pkg::OP_READ:
          in_status = (!in_bounds || off_bad) ? nfw_pkg::STAT_BOUNDS : nfw_pkg::STAT_OK;
        nfw_pkg::OP_WRITE: begin
          if (wr_mis) begin
            in_status = nfw_pkg::STAT_MISALIGN;
          end else if (!in_bounds || off_bad) begin
            in_status = nfw_pkg::STAT_BOUNDS;
          end else begin
            in_status = nfw_pkg::STAT_OK;
          end
        end
        nfw_pkg::OP_ERASE: begin
          if (er_mis) begin
            in_status = nfw_pkg::STAT_MISALIGN;
          end else if (!in_bounds) begin
            in_status = nfw_pkg::STAT_BOUNDS;
          end else begin
            in_status = nfw_pkg::STAT_OK;
          end
        end
        nfw_pkg::OP_NOP:
          in_status = nfw_pkg::STAT_OK;
        default:
          in_status = nfw_pkg::STAT_OK;
      endcase
    end
  end

  // item registers
  nfw_pkg::state_t   state;
  nfw_pkg::state_t   state_next;
  nfw_pkg::op_t      cur_op;
  nfw_pkg::status_t  cur_status;
  logic [AW-1:0]     cur_addr;
  logic [LW-1:0]     cur_len;
  logic [AW-1:0]     cur_baddr;
  logic [7:0]        cur_wd;
  logic              cur_mb;
  logic [SW-1:0]     cur_sec;
  logic [LW-1:0]     fill_cnt;
  logic signed [WW-1:0] erase_wear;

  logic              out_valid;
  logic [31:0]       out_data;

  nfw_pkg::byte_req_t byte_req;
  nfw_pkg::wear_req_t wear_req;
  logic [7:0]         byte_rd;
  logic signed [WW-1:0] wear_rd;

  nfw_byte_ram u_byte_ram (
    .clk   (clk),
    .req   (byte_req),
    .rdata (byte_rd)
  );

  nfw_wear_ram u_wear_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (wear_req),
    .rdata (wear_rd)
  );

  logic                 accept;
  logic                 slot_free;
  logic                 cur_ok;
  logic                 load_out;
  logic                 start_fill;
  logic                 fill_step;
  logic [31:0]          res_data;
  logic signed [WW-1:0] w_inc;
  logic signed [WW-1:0] w_new;
  logic [7:0]           res_rdata;
  logic signed [WW-1:0] res_wear;

  assign s_tready  = (state == nfw_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;
  assign cur_ok    = (cur_status == nfw_pkg::STAT_OK);

  always_comb begin
    w_inc = (wear_rd != nfw_pkg::WEAR_MAX) ? wear_rd + 16'sd1 : wear_rd;
    w_new = (bad_enable && cur_mb) ? -w_inc : w_inc;

    if (cur_op == nfw_pkg::OP_READ && cur_ok) begin
      res_rdata = (wear_rd < 0) ? nfw_pkg::BAD_READ : byte_rd;
    end else begin
      res_rdata = 8'd0;
    end
    res_wear = cur_ok ? wear_rd : '0;

    state_next     = state;
    load_out       = 1'b0;
    start_fill     = 1'b0;
    fill_step      = 1'b0;
    res_data       = {6'd0, res_wear, res_rdata, cur_status};
    byte_req       = '0;
    wear_req       = '0;

    unique case (state)
      nfw_pkg::ST_IDLE: begin
        if (accept) begin
          byte_req.ren  = 1'b1;
          byte_req.addr = in_addr + in_off;
          wear_req.ren  = 1'b1;
          wear_req.addr = in_sec;
          state_next    = nfw_pkg::ST_ACCESS;
        end
      end
      nfw_pkg::ST_ACCESS: begin
        if (cur_op == nfw_pkg::OP_ERASE && cur_ok) begin
          wear_req.wen   = 1'b1;
          wear_req.addr  = cur_sec;
          wear_req.wdata = w_new;
          start_fill     = 1'b1;
          state_next     = nfw_pkg::ST_FILL;
        end else if (slot_free) begin
          if (cur_op == nfw_pkg::OP_WRITE && cur_ok) begin
            byte_req.wen   = 1'b1;
            byte_req.addr  = cur_baddr;
            byte_req.wdata = byte_rd & cur_wd;
          end
          load_out   = 1'b1;
          state_next = nfw_pkg::ST_IDLE;
        end
      end
      nfw_pkg::ST_FILL: begin
        res_data = {6'd0, erase_wear, 8'd0, nfw_pkg::STAT_OK};
        if (fill_cnt != cur_len) begin
          byte_req.wen   = 1'b1;
          byte_req.addr  = cur_addr + fill_cnt[AW-1:0];
          byte_req.wdata = nfw_pkg::ERASED_BYTE;
          fill_step      = 1'b1;
        end else if (slot_free) begin
          load_out   = 1'b1;
          state_next = nfw_pkg::ST_IDLE;
        end
      end
      default: state_next = nfw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nfw_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op     <= in_op;
      cur_status <= in_status;
      cur_addr   <= in_addr;
      cur_len    <= in_len;
      cur_baddr  <= in_addr + in_off;
      cur_wd     <= in_wd;
      cur_mb     <= in_mb;
      cur_sec    <= in_sec;
    end
    if (start_fill) begin
      fill_cnt   <= '0;
      erase_wear <= w_new;
    end else if (fill_step) begin
      fill_cnt <= fill_cnt + LW'(1);
    end
    if (load_out) begin
      out_data <= res_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
`default_nettype wire

>>> dv/flash_result_checker.sv
// ----------------------------------------------------------------------------
// flash_result_checker
// Watches the item and result channels of the NOR flash model, predicts each
// result from its own byte store and wear table, and compares field by field.
// ----------------------------------------------------------------------------
module flash_result_checker
  import nfw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [63:0]           s_tdata,
  input  wire logic [1:0]            s_tuser,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [31:0]           m_tdata,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct {
    status_t                  status;
    logic [7:0]               rdata;
    logic signed [WEAR_W-1:0] wear;
  } flash_reply_t;

  flash_reply_t             replies[$];
  logic [7:0]               byte_mirror [MEM_BYTES];
  logic signed [WEAR_W-1:0] wear_mirror [NUM_SECTORS];

  logic        area_open;
  logic [3:0]  gran_log2;
  logic [4:0]  sector_log2;
  logic [16:0] area_bytes;
  logic        bad_enable;
  int          errors;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    errors      = 0;
    foreach (byte_mirror[i]) byte_mirror[i] = '0;
  end

  function automatic flash_reply_t apply_flash_op(op_t op, logic [63:0] d);
    int           addr, len, off, lim, shift, g, mask, w, sec, i;
    logic [7:0]   wd;
    logic         mb;
    flash_reply_t r;
    addr  = int'(d[15:0]);
    len   = int'(d[32:16]);
    off   = int'(d[48:33]);
    wd    = d[56:49];
    mb    = d[57];
    shift = (sector_log2 < 8) ? 8 : (sector_log2 > 16) ? 16 : int'(sector_log2);
    sec   = (addr >> shift) % NUM_SECTORS;
    lim   = (area_bytes > MEM_BYTES) ? MEM_BYTES : int'(area_bytes);
    r.status = STAT_OK;
    r.rdata  = '0;
    if (!area_open) begin
      r.status = STAT_CLOSED;
    end else begin
      case (op)
        OP_READ: begin
          if (addr + len > lim || off >= len) r.status = STAT_BOUNDS;
          else if (wear_mirror[sec] < 0) r.rdata = BAD_READ;
          else r.rdata = byte_mirror[addr + off];
        end
        OP_WRITE: begin
          g    = (gran_log2 > 8) ? 8 : int'(gran_log2);
          mask = (1 << g) - 1;
          if ((addr & mask) != 0 || (len & mask) != 0) r.status = STAT_MISALIGN;
          else if (addr + len > lim || off >= len) r.status = STAT_BOUNDS;
          else byte_mirror[addr + off] = byte_mirror[addr + off] & wd;
        end
        OP_ERASE: begin
          mask = (1 << shift) - 1;
          if ((addr & mask) != 0) begin
            r.status = STAT_MISALIGN;
          end else if (addr + len > lim) begin
            r.status = STAT_BOUNDS;
          end else begin
            for (i = 0; i < len; i++) byte_mirror[addr + i] = ERASED_BYTE;
            w = wear_mirror[sec];
            if (w < int'(WEAR_MAX)) w = w + 1;
            if (bad_enable && mb) w = -w;
            wear_mirror[sec] = w[WEAR_W-1:0];
          end
        end
        default: ;
      endcase
    end
    r.wear = (r.status == STAT_OK) ? wear_mirror[sec] : '0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    flash_reply_t             want;
    status_t                  got_status;
    logic [7:0]               got_rdata;
    logic signed [WEAR_W-1:0] got_wear;
    if (rst) begin
      replies.delete();
      area_open   = 1'b0;
      gran_log2   = 4'd0;
      sector_log2 = 5'd12;
      area_bytes  = 17'd65536;
      bad_enable  = 1'b0;
      foreach (wear_mirror[i]) wear_mirror[i] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AREA_OPEN:   area_open   = cfg_wdata[0];
          CFG_GRAN_LOG2:   gran_log2   = cfg_wdata[3:0];
          CFG_SECTOR_LOG2: sector_log2 = cfg_wdata[4:0];
          CFG_AREA_BYTES:  area_bytes  = cfg_wdata[16:0];
          CFG_BAD_ENABLE:  bad_enable  = cfg_wdata[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got_status = status_t'(m_tdata[1:0]);
        got_rdata  = m_tdata[9:2];
        got_wear   = m_tdata[25:10];
        if (replies.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: tdata %h", m_tdata);
        end else begin
          want = replies.pop_front();
          if (want.status !== got_status || want.rdata !== got_rdata ||
              want.wear !== got_wear) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: status %0d/%0d rdata %h/%h wear %0d/%0d (exp/got)",
                       want.status, got_status, want.rdata, got_rdata,
                       want.wear, got_wear);
          end
        end
      end
      if (s_tvalid && s_tready)
        replies.push_back(apply_flash_op(op_t'(s_tuser), s_tdata));
    end
    mismatches  <= errors;
    outstanding <= replies.size();
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random flash items and register settings into the NOR
// flash model under several idling patterns and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import nfw_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata   = '0;
  logic [1:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [31:0]           m_tdata;

  int mismatches;
  int outstanding;
  int src_idle   = 0;
  int sink_stall = 0;
  int cur_gran   = 0;
  int cur_sector = 12;
  int cur_area   = 65536;

  always #2 clk = ~clk;

  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_stall);

  nor_flash_model_with_wear_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  flash_result_checker result_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  task automatic send_op(op_t op, logic [15:0] addr, logic [16:0] len,
                         logic [15:0] off, logic [7:0] wd, logic mb);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, mb, wd, off, len, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_apply(int open, int gran, int sector, int area, int bad);
    s_tvalid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_AREA_OPEN;
    cfg_wdata <= 17'(open);
    @(posedge clk);
    cfg_index <= CFG_GRAN_LOG2;
    cfg_wdata <= 17'(gran);
    @(posedge clk);
    cfg_index <= CFG_SECTOR_LOG2;
    cfg_wdata <= 17'(sector);
    @(posedge clk);
    cfg_index <= CFG_AREA_BYTES;
    cfg_wdata <= 17'(area);
    @(posedge clk);
    cfg_index <= CFG_BAD_ENABLE;
    cfg_wdata <= 17'(bad);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_gran   = gran;
    cur_sector = sector;
    cur_area   = area;
  endtask

  task automatic rand_item();
    int   r, lim, g, sh, unit, addr, len, maxlen;
    op_t  op;
    lim = (cur_area > MEM_BYTES) ? MEM_BYTES : cur_area;
    g   = (cur_gran > 8) ? 8 : cur_gran;
    sh  = (cur_sector < 8) ? 8 : (cur_sector > 16) ? 16 : cur_sector;
    r   = $urandom_range(99);
    op  = (r < 35) ? OP_READ : (r < 65) ? OP_WRITE : (r < 90) ? OP_ERASE : OP_NOP;
    if ($urandom_range(99) < 15 || lim < 256) begin
      send_op(op_t'($urandom_range(3)), 16'($urandom), 17'($urandom_range(65536)),
              16'($urandom), 8'($urandom), 1'($urandom));
    end else if (op == OP_ERASE) begin
      unit   = 1 << sh;
      addr   = $urandom_range((lim - 1) / unit) * unit;
      maxlen = lim - addr;
      if ($urandom_range(199) == 0) len = $urandom_range(maxlen);
      else len = $urandom_range((maxlen < 256) ? maxlen : 256);
      send_op(OP_ERASE, 16'(addr), 17'(len), 16'($urandom), 8'($urandom),
              $urandom_range(9) < 3);
    end else if (op == OP_NOP) begin
      send_op(OP_NOP, 16'($urandom), 17'($urandom_range(65536)), 16'($urandom),
              8'($urandom), 1'($urandom));
    end else begin
      unit = (op == OP_WRITE) ? (1 << g) : 1;
      len  = ($urandom_range(3) == 0) ? $urandom_range(lim, 1) : $urandom_range(64, 1);
      len  = (len / unit) * unit;
      if (len == 0) len = unit;
      addr = $urandom_range((lim - len) / unit) * unit;
      send_op(op, 16'(addr), 17'(len), 16'($urandom_range(len - 1)), 8'($urandom),
              1'($urandom));
    end
  endtask

  initial begin
    int seg, r, area;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // area still closed
    send_op(OP_READ, 16'h0000, 17'd1, 16'h0000, 8'h00, 1'b0);
    send_op(OP_NOP, 16'hffff, 17'd65536, 16'hffff, 8'hff, 1'b1);
    wait_idle();
    cfg_apply(1, 0, 12, 65536, 0);
    // whole area erased once so every byte is defined from here on
    send_op(OP_ERASE, 16'h0000, 17'd65536, 16'h0000, 8'h00, 1'b0);
    send_op(OP_READ, 16'h0000, 17'd1, 16'h0000, 8'h00, 1'b0);
    send_op(OP_WRITE, 16'hffff, 17'd1, 16'h0000, 8'h00, 1'b0);
    send_op(OP_READ, 16'hffff, 17'd1, 16'h0000, 8'hff, 1'b0);
    send_op(OP_WRITE, 16'h1234, 17'h100, 16'h0005, 8'h0f, 1'b0);
    send_op(OP_READ, 16'h1234, 17'h100, 16'h0005, 8'h00, 1'b0);
    send_op(OP_READ, 16'h0000, 17'd65536, 16'hffff, 8'h00, 1'b0);
    send_op(OP_READ, 16'h0010, 17'd4, 16'h0004, 8'h00, 1'b0);
    send_op(OP_READ, 16'h0000, 17'd0, 16'h0000, 8'h00, 1'b0);
    send_op(OP_READ, 16'hffff, 17'd2, 16'h0000, 8'h00, 1'b0);
    send_op(OP_ERASE, 16'h0800, 17'd16, 16'h0000, 8'h00, 1'b0);
    send_op(OP_ERASE, 16'h1000, 17'd0, 16'h0000, 8'h00, 1'b0);
    send_op(OP_ERASE, 16'hf000, 17'h1001, 16'h0000, 8'h00, 1'b0);
    send_op(OP_NOP, 16'hffff, 17'd0, 16'h0000, 8'h00, 1'b0);
    wait_idle();
    cfg_apply(1, 3, 12, 65536, 1);
    send_op(OP_WRITE, 16'h0004, 17'd8, 16'h0000, 8'h00, 1'b0);
    send_op(OP_WRITE, 16'h0008, 17'd12, 16'h0000, 8'h00, 1'b0);
    send_op(OP_WRITE, 16'h0008, 17'd8, 16'h0003, 8'ha5, 1'b0);
    send_op(OP_WRITE, 16'hfff8, 17'd16, 16'h0000, 8'h00, 1'b0);
    // bad sector: marked, read back as the bad-read pattern 0x55, then worn again
    send_op(OP_ERASE, 16'h2000, 17'd16, 16'h0000, 8'h00, 1'b1);
    send_op(OP_READ, 16'h2000, 17'd16, 16'h0003, 8'h00, 1'b0);
    send_op(OP_ERASE, 16'h2000, 17'd16, 16'h0000, 8'h00, 1'b0);
    send_op(OP_ERASE, 16'h2000, 17'd16, 16'h0000, 8'h00, 1'b1);
    wait_idle();
    cfg_apply(1, 15, 31, 131071, 0);
    send_op(OP_WRITE, 16'h0100, 17'h100, 16'h00ff, 8'hff, 1'b0);
    send_op(OP_ERASE, 16'h8000, 17'd0, 16'h0000, 8'h00, 1'b0);
    send_op(OP_ERASE, 16'h0000, 17'd16, 16'h0000, 8'h00, 1'b1);
    wait_idle();
    cfg_apply(1, 0, 0, 0, 0);
    send_op(OP_READ, 16'h0000, 17'd0, 16'h0000, 8'h00, 1'b0);
    send_op(OP_ERASE, 16'h0000, 17'd0, 16'h0000, 8'h00, 1'b0);
    send_op(OP_WRITE, 16'h0000, 17'd1, 16'h0000, 8'h00, 1'b0);
    wait_idle();

    // repeated wear on the top sector, then marked bad
    cfg_apply(1, 0, 8, 65536, 0);
    repeat (20) send_op(OP_ERASE, 16'hff00, 17'd0, 16'h0000, 8'h00, 1'b0);
    wait_idle();
    cfg_apply(1, 0, 8, 65536, 1);
    send_op(OP_ERASE, 16'hff00, 17'd0, 16'h0000, 8'h00, 1'b1);
    send_op(OP_READ, 16'hff00, 17'd1, 16'h0000, 8'h00, 1'b0);
    send_op(OP_ERASE, 16'hff00, 17'd1, 16'h0000, 8'h00, 1'b0);
    wait_idle();

    for (seg = 0; seg < 17; seg++) begin
      case (seg % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 81; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 81; end
        default: begin src_idle = 29; sink_stall = 29; end
      endcase
      r = $urandom_range(9);
      area = (r < 5) ? 65536 : (r < 7) ? $urandom_range(131071) :
             (r < 8) ? 131071 : $urandom_range(65536, 256);
      cfg_apply($urandom_range(9) != 0,
                ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3),
                ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(12, 8),
                area, $urandom_range(1));
      repeat (47) rand_item();
      wait_idle();
    end

    s_tvalid   <= 1'b0;
    sink_stall = 0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
